### design/voltmeter_min_max_display_top_macros.svh
// ----------------------------------------------------------------------------
// voltmeter_min_max_display_top_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef VOLTMETER_MIN_MAX_DISPLAY_TOP_MACROS_SVH
`define VOLTMETER_MIN_MAX_DISPLAY_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMPL(name, pre, post) \
name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error("assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NEXT(name, pre, post) \
name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("assertion failed");

`endif

### design/vmmd_pkg.sv
// ----------------------------------------------------------------------------
// vmmd_pkg
// Types, codes and small helper functions of the averaging voltmeter.
// ----------------------------------------------------------------------------
package vmmd_pkg;

	localparam int SAMPLES_PER_AVERAGE_DEF = 8;
	localparam int QUEUE_DEPTH = 4;

	localparam int SAMPLE_W = 10;
	localparam int VOLT_W = 6;

	// input actions
	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_RX = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_MEAS = 2'd0;
	localparam logic [1:0] KIND_DISP = 2'd1;
	localparam logic [1:0] KIND_TX = 2'd2;

	localparam logic [5:0] VOLT_FULL = 6'd33;
	localparam logic [15:0] SCALE_ROUND = 16'd511;
	localparam logic [10:0] SCALE_DIV = 11'd1023;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] QUERY_MAX = 8'h4D;
	localparam logic [7:0] QUERY_MIN = 8'h6D;

	typedef struct packed {
		logic [1:0] action;
		logic [SAMPLE_W-1:0] sample;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [VOLT_W-1:0] measured;
		logic [6:0] segments;
		logic tens_digit_on;
		logic [7:0] tx_byte;
		logic last;
	} result_t;

	// results produced by one transaction, res0 first
	typedef struct packed {
		logic [1:0] count;
		result_t res0;
		result_t res1;
	} push_t;

	// average code to tenths of a volt: (avg*33+511)/1023
	function automatic logic [VOLT_W-1:0] scale_volt(input logic [SAMPLE_W-1:0] avg);
		logic [15:0] scaled;
		logic [5:0] q0;
		logic [10:0] rem;
		scaled = 16'({avg, 5'b00000}) + 16'(avg) + SCALE_ROUND;
		q0 = scaled[15:10];
		// x - q0*1023 = x[9:0] + q0, always below twice the divisor
		rem = 11'(scaled[9:0]) + 11'(q0);
		return (rem >= SCALE_DIV) ? 6'(q0 + 6'd1) : q0;
	endfunction

	function automatic logic [3:0] tens_of(input logic [VOLT_W-1:0] v);
		logic [3:0] t;
		if (v >= 6'd30) begin
			t = 4'd3;
		end else if (v >= 6'd20) begin
			t = 4'd2;
		end else if (v >= 6'd10) begin
			t = 4'd1;
		end else begin
			t = 4'd0;
		end
		return t;
	endfunction

	function automatic logic [3:0] units_of(input logic [VOLT_W-1:0] v);
		logic [3:0] t;
		logic [5:0] tenfold;
		t = tens_of(v);
		tenfold = 6'({t, 3'b000}) + 6'({t, 1'b0});
		return 4'(v - tenfold);
	endfunction

	// segment bits a..g at bit 0..6
	function automatic logic [6:0] segment_code(input logic [3:0] d);
		logic [6:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

### design/voltmeter_min_max_display_top.sv
// ----------------------------------------------------------------------------
// voltmeter_min_max_display_top
// Averaging voltmeter with running min/max, seven-segment and serial output.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle: a converter sample, a display refresh tick
// or a received serial byte. Each is registered, then processed against
// the batch sum, voltage and min/max registers, and its results written into
// a four-entry result queue, so a result passes the input register and a queue
// entry before it can be taken. A query byte gives two results, which leave the
// queue one after the other. The input stalls only while fewer than two queue
// slots are free, so with an unstalled output the sustained rate is one
// transaction per cycle, except that back-to-back query bytes are slowed to
// the pace of the single result port.
module voltmeter_min_max_display_top #(
	parameter int SAMPLES_PER_AVERAGE = vmmd_pkg::SAMPLES_PER_AVERAGE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  vmmd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output vmmd_pkg::result_t result
);

	logic valid_s1;
	vmmd_pkg::item_t item_s1;
	logic room;
	logic fire;
	vmmd_pkg::push_t push;

	assign fire = valid_s1 && room;
	assign item_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	vmmd_core #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.push    (push)
	);

	vmmd_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### design/vmmd_core.sv
// ----------------------------------------------------------------------------
// vmmd_core
// Batch averaging, min/max tracking, display digit and serial reply logic.
// ----------------------------------------------------------------------------
module vmmd_core #(
	parameter int SAMPLES_PER_AVERAGE = vmmd_pkg::SAMPLES_PER_AVERAGE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  vmmd_pkg::item_t item_s1,
	output vmmd_pkg::push_t push
);

	localparam int CntW = $clog2(SAMPLES_PER_AVERAGE);
	localparam int SumW = vmmd_pkg::SAMPLE_W + CntW;
	localparam int ShiftK = SumW + CntW;
	localparam int ProdW = SumW + ShiftK;
	// rounded-up reciprocal, exact for every sum below 2**SumW
	localparam logic [ShiftK-1:0] DivMul =
		ShiftK'(((1 << ShiftK) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
	localparam logic [CntW-1:0] CntLast = CntW'(SAMPLES_PER_AVERAGE - 1);

	logic [SumW-1:0] sum_q;
	logic [CntW-1:0] count_q;
	logic [vmmd_pkg::VOLT_W-1:0] volt_now_q;
	logic [vmmd_pkg::VOLT_W-1:0] volt_low_q;
	logic [vmmd_pkg::VOLT_W-1:0] volt_high_q;
	logic toggle_q;

	logic [SumW-1:0] sum_next;
	logic [ProdW-1:0] prod;
	logic [vmmd_pkg::SAMPLE_W-1:0] avg;
	logic [vmmd_pkg::VOLT_W-1:0] volt;
	logic batch_done;
	logic [vmmd_pkg::VOLT_W-1:0] reply_volt;

	assign sum_next = sum_q + SumW'(item_s1.sample);
	assign batch_done = (count_q == CntLast);
	assign prod = ProdW'(sum_next) * ProdW'(DivMul);
	assign avg = prod[ShiftK +: vmmd_pkg::SAMPLE_W];
	assign volt = vmmd_pkg::scale_volt(avg);
	assign reply_volt = (item_s1.rx_byte == vmmd_pkg::QUERY_MAX) ? volt_high_q : volt_low_q;

	always_comb begin
		push = '0;
		case (item_s1.action)
			vmmd_pkg::ACT_SAMPLE: begin
				if (batch_done) begin
					push.count = 2'd1;
					push.res0.kind = vmmd_pkg::KIND_MEAS;
					push.res0.measured = volt;
					push.res0.last = 1'b1;
				end
			end
			vmmd_pkg::ACT_TICK: begin
				push.count = 2'd1;
				push.res0.kind = vmmd_pkg::KIND_DISP;
				push.res0.tens_digit_on = !toggle_q;
				push.res0.segments = vmmd_pkg::segment_code(toggle_q ?
					vmmd_pkg::units_of(volt_now_q) : vmmd_pkg::tens_of(volt_now_q));
				push.res0.last = 1'b1;
			end
			vmmd_pkg::ACT_RX: begin
				if (item_s1.rx_byte == vmmd_pkg::QUERY_MAX ||
						item_s1.rx_byte == vmmd_pkg::QUERY_MIN) begin
					push.count = 2'd2;
					push.res0.kind = vmmd_pkg::KIND_TX;
					push.res0.tx_byte = vmmd_pkg::ASCII_ZERO +
						8'(vmmd_pkg::tens_of(reply_volt));
					push.res1.kind = vmmd_pkg::KIND_TX;
					push.res1.tx_byte = vmmd_pkg::ASCII_ZERO +
						8'(vmmd_pkg::units_of(reply_volt));
					push.res1.last = 1'b1;
				end
			end
			default: begin
				push = '0;
			end
		endcase
		if (!fire) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
			volt_now_q <= '0;
			volt_low_q <= vmmd_pkg::VOLT_FULL;
			volt_high_q <= '0;
			toggle_q <= 1'b0;
		end else if (fire) begin
			if (item_s1.action == vmmd_pkg::ACT_SAMPLE) begin
				if (batch_done) begin
					// each batch starts from an empty sum
					sum_q <= '0;
					count_q <= '0;
					volt_now_q <= volt;
					if (volt > volt_high_q) begin
						volt_high_q <= volt;
					end
					if (volt < volt_low_q) begin
						volt_low_q <= volt;
					end
				end else begin
					sum_q <= sum_next;
					count_q <= count_q + CntW'(1);
				end
			end else if (item_s1.action == vmmd_pkg::ACT_TICK) begin
				toggle_q <= !toggle_q;
			end
		end
	end

endmodule

### design/vmmd_queue.sv
// ----------------------------------------------------------------------------
// vmmd_queue
// Small result queue, up to two results in per cycle, one out unless stalled.
// ----------------------------------------------------------------------------
module vmmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  vmmd_pkg::push_t   push,
	output logic              room,
	output logic              result_valid,
	input  logic              result_stall,
	output vmmd_pkg::result_t result
);

	localparam int PtrW = $clog2(vmmd_pkg::QUEUE_DEPTH);
	localparam int CntW = PtrW + 1;

	vmmd_pkg::result_t entry_q [vmmd_pkg::QUEUE_DEPTH];
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW-1:0] wr_ptr_q;
	logic [CntW-1:0] count_q;
	logic pop;

	assign result_valid = (count_q != '0);
	assign result = entry_q[rd_ptr_q];
	assign pop = result_valid && !result_stall;
	// two free slots needed, whatever the output does this cycle
	assign room = (count_q <= CntW'(vmmd_pkg::QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.res0;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_q + PtrW'(1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			wr_ptr_q <= wr_ptr_q + PtrW'(push.count);
			count_q <= count_q + CntW'(push.count) - CntW'(pop);
		end
	end

endmodule

### design/vmmd_checker.sv
// ----------------------------------------------------------------------------
// vmmd_checker
// Port-level checks of the voltmeter, bound to the top level.
// ----------------------------------------------------------------------------
`include "voltmeter_min_max_display_top_macros.svh"

module vmmd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input vmmd_pkg::result_t result
);

	logic out_fire;
	logic tx_first;
	logic tx_final;

	assign out_fire = result_valid && !result_stall;
	assign tx_first = (result.kind == vmmd_pkg::KIND_TX) && !result.last;
	assign tx_final = (result.kind == vmmd_pkg::KIND_TX) && result.last;

	// a stalled result transaction holds
	`ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

	// the first reply byte is always followed by the closing one
	`ASSERT_NEXT(a_reply_pair, out_fire && tx_first, result_valid && tx_final)

	// input only backs up when results are waiting
	`ASSERT_IMPL(a_stall_cause, item_stall, result_valid)

endmodule

bind voltmeter_min_max_display_top vmmd_checker u_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the averaging voltmeter with min/max and display.
// A queue-fed driver offers samples, refresh ticks and serial bytes with random
// gaps while a clocked monitor keeps its own meter state, builds the expected
// results of every accepted transaction and checks each delivered result.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int BATCH = vmmd_pkg::SAMPLES_PER_AVERAGE_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;
	// action code with no meaning, must be ignored
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	// segment patterns, digit 0 in the low seven bits
	localparam logic [69:0] DIGIT_SEGS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
		7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

	typedef struct packed {
		vmmd_pkg::item_t payload;
		logic [3:0] gap;
	} pending_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	vmmd_pkg::item_t item;
	logic result_valid;
	logic result_stall;
	vmmd_pkg::result_t result;

	voltmeter_min_max_display_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// meter state as the block should hold it
	logic [12:0] sum_acc;
	int batch_fill;
	logic [5:0] volt_now;
	logic [5:0] volt_low;
	logic [5:0] volt_high;
	logic units_next;

	pending_t queued_items[$];
	vmmd_pkg::result_t due_results[$];

	int queued_total = 0;
	int accepted_items = 0;
	int error_count = 0;
	int cycle_count = 0;
	int meas_seen = 0;
	int disp_seen = 0;
	int tx_seen = 0;

	// driver side
	pending_t cur;
	logic loaded = 1'b0;
	int gap_left = 0;
	logic item_taken = 1'b0;
	logic sender_quiet = 1'b0;

	// receiver side
	int rx_wait = 0;
	int hold_left = 0;
	logic hold_req = 1'b0;
	logic rx_no_idle = 1'b0;

	function automatic void meter_apply(input vmmd_pkg::item_t it);
		vmmd_pkg::result_t r;
		int avg;
		int v;
		int digit;
		r = '0;
		case (it.action)
			vmmd_pkg::ACT_SAMPLE: begin
				sum_acc = sum_acc + 13'(it.sample);
				batch_fill++;
				if (batch_fill == BATCH) begin
					avg = int'(sum_acc) / BATCH;
					sum_acc = '0;
					batch_fill = 0;
					v = (avg * 33 + 511) / 1023;
					volt_now = 6'(v);
					if (volt_now > volt_high) volt_high = volt_now;
					if (volt_now < volt_low) volt_low = volt_now;
					r.kind = vmmd_pkg::KIND_MEAS;
					r.measured = volt_now;
					r.last = 1'b1;
					due_results.push_back(r);
				end
			end
			vmmd_pkg::ACT_TICK: begin
				digit = units_next ? int'(volt_now) % 10 : int'(volt_now) / 10;
				r.kind = vmmd_pkg::KIND_DISP;
				r.tens_digit_on = ~units_next;
				r.segments = DIGIT_SEGS[digit*7 +: 7];
				r.last = 1'b1;
				due_results.push_back(r);
				units_next = ~units_next;
			end
			vmmd_pkg::ACT_RX: begin
				if (it.rx_byte == vmmd_pkg::QUERY_MAX || it.rx_byte == vmmd_pkg::QUERY_MIN) begin
					v = (it.rx_byte == vmmd_pkg::QUERY_MAX) ? int'(volt_high) : int'(volt_low);
					r.kind = vmmd_pkg::KIND_TX;
					r.tx_byte = vmmd_pkg::ASCII_ZERO + 8'(v / 10);
					due_results.push_back(r);
					r.tx_byte = vmmd_pkg::ASCII_ZERO + 8'(v % 10);
					r.last = 1'b1;
					due_results.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void push_item(input logic [1:0] act, input int smp, input int rxb);
		pending_t p;
		p.payload.action = act;
		p.payload.sample = smp[vmmd_pkg::SAMPLE_W-1:0];
		p.payload.rx_byte = 8'(rxb);
		p.gap = sender_quiet ? 4'd0 : 4'($urandom_range(0, 11));
		queued_items.push_back(p);
		queued_total++;
	endfunction

	task automatic drain_all();
		while (accepted_items != queued_total || due_results.size() != 0) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("voltmeter_min_max_display_top verification failed");
			$finish;
		end
	end

	// driver: one item in flight, gap counted before it is offered
	always @(negedge clk) begin
		if (arst_n && !(item_valid && !item_taken)) begin
			item_taken = 1'b0;
			if (!loaded && queued_items.size() > 0) begin
				cur = queued_items.pop_front();
				loaded = 1'b1;
				gap_left = int'(cur.gap);
			end
			if (loaded && gap_left == 0) begin
				item_valid <= 1'b1;
				item <= cur.payload;
				loaded = 1'b0;
			end else begin
				item_valid <= 1'b0;
				if (loaded) gap_left--;
			end
		end
	end

	// receiver stall: long hold on request, else per-result wait
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// monitor: predict on accepted input, check each delivered result
	always @(posedge clk) begin
		vmmd_pkg::result_t want;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				meter_apply(item);
				accepted_items++;
				item_taken = 1'b1;
			end
			if (result_valid && !result_stall) begin
				rx_wait = rx_no_idle ? 0 : $urandom_range(0, 11);
				case (result.kind)
					vmmd_pkg::KIND_MEAS: meas_seen++;
					vmmd_pkg::KIND_DISP: disp_seen++;
					default: tx_seen++;
				endcase
				if (due_results.size() == 0) begin
					$error("result with no transaction pending: kind %0d", result.kind);
					error_count++;
				end else begin
					want = due_results.pop_front();
					if (result.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, result.kind);
						error_count++;
					end
					if (result.measured !== want.measured) begin
						$error("measured: expected %0d, got %0d", want.measured,
							result.measured);
						error_count++;
					end
					if (result.segments !== want.segments) begin
						$error("segments: expected %h, got %h", want.segments,
							result.segments);
						error_count++;
					end
					if (result.tens_digit_on !== want.tens_digit_on) begin
						$error("tens_digit_on: expected %0d, got %0d", want.tens_digit_on,
							result.tens_digit_on);
						error_count++;
					end
					if (result.tx_byte !== want.tx_byte) begin
						$error("tx_byte: expected %h, got %h", want.tx_byte, result.tx_byte);
						error_count++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, result.last);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		int level;
		int batch_pos;
		int pick;
		int smp;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		sum_acc = '0;
		batch_fill = 0;
		volt_now = '0;
		volt_low = vmmd_pkg::VOLT_FULL;
		volt_high = '0;
		units_next = 1'b0;
		level = 0;
		batch_pos = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: queries and display before any measurement, ignored inputs,
		// full-scale and zero batches
		push_item(vmmd_pkg::ACT_RX, 0, vmmd_pkg::QUERY_MAX);
		push_item(vmmd_pkg::ACT_RX, 0, vmmd_pkg::QUERY_MIN);
		push_item(vmmd_pkg::ACT_TICK, 1023, 255);
		push_item(vmmd_pkg::ACT_TICK, 0, 0);
		push_item(ACT_UNUSED, 1023, 255);
		push_item(vmmd_pkg::ACT_RX, 1023, 0);
		push_item(vmmd_pkg::ACT_RX, 0, 255);
		repeat (BATCH) push_item(vmmd_pkg::ACT_SAMPLE, 1023, 255);
		push_item(vmmd_pkg::ACT_TICK, 0, 0);
		push_item(vmmd_pkg::ACT_TICK, 0, 0);
		push_item(vmmd_pkg::ACT_RX, 0, vmmd_pkg::QUERY_MAX);
		repeat (BATCH) push_item(vmmd_pkg::ACT_SAMPLE, 0, 0);
		push_item(vmmd_pkg::ACT_RX, 0, vmmd_pkg::QUERY_MIN);
		push_item(vmmd_pkg::ACT_TICK, 0, 0);
		drain_all();

		for (int chunk = 0; chunk < 12; chunk++) begin
			if (chunk == 6) begin
				// sender waits for everything, then receiver holds off under a burst
				drain_all();
				@(posedge clk);
				hold_req = 1'b1;
				sender_quiet = 1'b1;
				for (int k = 0; k < 30; k++) begin
					if ($urandom_range(0, 1)) begin
						push_item(vmmd_pkg::ACT_TICK, $urandom_range(0, 1023), 0);
					end else begin
						push_item(vmmd_pkg::ACT_RX, 0,
							$urandom_range(0, 1) ? vmmd_pkg::QUERY_MAX : vmmd_pkg::QUERY_MIN);
					end
				end
				drain_all();
			end
			sender_quiet = ($urandom_range(0, 3) == 0);
			rx_no_idle = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 50; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					if (batch_pos == 0) level = $urandom_range(0, 1023);
					batch_pos = (batch_pos + 1) % BATCH;
					if ($urandom_range(0, 3) == 0) begin
						smp = $urandom_range(0, 1023);
					end else begin
						smp = level + $urandom_range(0, 40) - 20;
						if (smp < 0) smp = 0;
						if (smp > 1023) smp = 1023;
					end
					push_item(vmmd_pkg::ACT_SAMPLE, smp, $urandom_range(0, 255));
				end else if (pick < 75) begin
					push_item(vmmd_pkg::ACT_TICK, $urandom_range(0, 1023),
						$urandom_range(0, 255));
				end else if (pick < 92) begin
					if ($urandom_range(0, 1))
						push_item(vmmd_pkg::ACT_RX, $urandom_range(0, 1023),
							$urandom_range(0, 1) ? vmmd_pkg::QUERY_MAX : vmmd_pkg::QUERY_MIN);
					else
						push_item(vmmd_pkg::ACT_RX, $urandom_range(0, 1023),
							$urandom_range(0, 255));
				end else begin
					push_item(ACT_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 255));
				end
			end
		end
		drain_all();
		repeat (20) @(negedge clk);

		if (due_results.size() != 0) begin
			$error("%0d expected results never arrived", due_results.size());
			error_count++;
		end
		$display("run covered %0d transactions in and %0d results out", accepted_items,
			meas_seen + disp_seen + tx_seen);
		$display("  %0d measurements, %0d display drives, %0d serial bytes, %0d errors",
			meas_seen, disp_seen, tx_seen, error_count);
		if (error_count == 0) begin
			$display("voltmeter_min_max_display_top verification clean");
		end else begin
			$display("voltmeter_min_max_display_top verification failed");
		end
		$finish;
	end

endmodule
